// ----- rtl/hhd_pkg.sv -----
// Shared types and constants for the HCI H4 packet deframer.
package hhd_pkg;

    // Largest packet (type byte + header + payload) the downstream buffer takes, plus margin
    localparam int BufferBytes = 1024;
    // Longest type-specific header, and the most bytes pushed on one accepted byte
    localparam int HdrMax      = 4;
    // Chunk size limit on either endpoint
    localparam int ChunkMax    = 1024;
    localparam int ChunkReset  = 64;

    localparam logic [7:0] KIND_CMD = 8'h01;
    localparam logic [7:0] KIND_ACL = 8'h02;
    localparam logic [7:0] KIND_SCO = 8'h03;
    localparam logic [7:0] KIND_EVT = 8'h04;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_CMD_CHUNK = 2'd1;
    localparam logic [1:0] CFG_ACL_CHUNK = 2'd2;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       ep;
        logic       pkt_last;
    } entry_t;

    typedef struct packed {
        logic [2:0]              count;
        entry_t [HdrMax-1:0]     data;
    } push_t;

endpackage

// ----- rtl/hhd_front.sv -----
// Front end: accepts stream bytes, parses H4 headers and pushes forwarded bytes.
module hhd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [7:0]     in_byte,
    output logic           in_stall,
    input  logic           enable,
    input  logic           room,
    output hhd_pkg::push_t push
);

    localparam logic [17:0] DropLimit = 18'(hhd_pkg::BufferBytes - 4);

    hhd_pkg::phase_t phase_reg, phase_next;
    logic [2:0]      kind_reg, kind_next;
    logic [2:0]      hcount_reg, hcount_next;
    logic [15:0]     remaining_reg, remaining_next;
    logic [7:0]      store_reg [hhd_pkg::HdrMax];

    logic        accept;
    logic        work;
    logic [2:0]  hl;
    logic        fwd;
    logic        ep;
    logic [2:0]  hcount_inc;
    logic [15:0] len;
    logic [17:0] total;

    assign in_stall = !room;
    assign accept   = in_valid && room;
    assign work     = accept && enable;

    always_comb
    begin
        case (kind_reg)
            hhd_pkg::KIND_CMD[2:0]: hl = 3'd3;
            hhd_pkg::KIND_ACL[2:0]: hl = 3'd4;
            hhd_pkg::KIND_SCO[2:0]: hl = 3'd3;
            default:                hl = 3'd2;
        endcase
    end

    assign fwd        = (kind_reg == hhd_pkg::KIND_CMD[2:0]) ||
                        (kind_reg == hhd_pkg::KIND_ACL[2:0]);
    assign ep         = (kind_reg == hhd_pkg::KIND_ACL[2:0]);
    assign hcount_inc = hcount_reg + 3'd1;
    // len is used only when the current byte is the last header byte, so it closes the length field
    assign len        = ep ? {in_byte, store_reg[2]} : {8'd0, in_byte};
    assign total      = 18'(len) + 18'(hl) + 18'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        kind_next      = kind_reg;
        hcount_next    = hcount_reg;
        remaining_next = remaining_reg;
        push           = '0;
        if (work)
        begin
            case (phase_reg)
                hhd_pkg::PH_HEADER:
                begin
                    hcount_next = hcount_inc;
                    if (hcount_inc >= hl)
                    begin
                        if (total > DropLimit)
                        begin
                            // drop the oversized packet's header; the bytes after it are parsed as type bytes
                            phase_next = hhd_pkg::PH_TYPE;
                        end
                        else
                        begin
                            if (fwd)
                            begin
                                push.count = hl;
                                for (int i = 0; i < hhd_pkg::HdrMax; i++)
                                begin
                                    push.data[i].data     = (3'(i) + 3'd1 == hl) ?
                                                            in_byte : store_reg[i];
                                    push.data[i].ep       = ep;
                                    push.data[i].pkt_last = (3'(i) + 3'd1 == hl) &&
                                                            (len == 16'd0);
                                end
                            end
                            remaining_next = len;
                            phase_next     = (len != 16'd0) ? hhd_pkg::PH_PAYLOAD :
                                                              hhd_pkg::PH_TYPE;
                        end
                    end
                end
                hhd_pkg::PH_PAYLOAD:
                begin
                    if (remaining_reg == 16'd0)
                    begin
                        phase_next = hhd_pkg::PH_TYPE;
                    end
                    else
                    begin
                        if (fwd)
                        begin
                            push.count            = 3'd1;
                            push.data[0].data     = in_byte;
                            push.data[0].ep       = ep;
                            push.data[0].pkt_last = (remaining_reg == 16'd1);
                        end
                        remaining_next = remaining_reg - 16'd1;
                        if (remaining_reg == 16'd1)
                        begin
                            phase_next = hhd_pkg::PH_TYPE;
                        end
                    end
                end
                default:
                begin
                    phase_next = hhd_pkg::PH_TYPE;
                    // unknown type bytes are skipped
                    if (in_byte inside {[hhd_pkg::KIND_CMD:hhd_pkg::KIND_EVT]})
                    begin
                        kind_next   = in_byte[2:0];
                        hcount_next = 3'd0;
                        phase_next  = hhd_pkg::PH_HEADER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= hhd_pkg::PH_TYPE;
            kind_reg      <= 3'd0;
            hcount_reg    <= 3'd0;
            remaining_reg <= 16'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            kind_reg      <= kind_next;
            hcount_reg    <= hcount_next;
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work && (phase_reg == hhd_pkg::PH_HEADER))
        begin
            store_reg[hcount_reg[1:0]] <= in_byte;
        end
    end

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == hhd_pkg::PH_PAYLOAD) |-> (remaining_reg != 16'd0))
        else $error("payload phase with nothing remaining");

    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 3'd0) |-> (work && fwd))
        else $error("push without an accepted byte of a forwarded packet");

endmodule

// ----- rtl/hhd_queue.sv -----
// Byte queue between parser and output stage: up to four writes, one read per cycle.
module hhd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  hhd_pkg::push_t  push,
    output logic            room,
    input  logic            pop,
    output hhd_pkg::entry_t head,
    output logic            not_empty
);

    localparam int QueueDepth = 8;
    localparam int PtrW       = $clog2(QueueDepth);
    localparam int CntW       = $clog2(QueueDepth + 1);

    hhd_pkg::entry_t mem_reg [QueueDepth];
    logic [PtrW-1:0] head_reg, head_next;
    logic [PtrW-1:0] tail_reg, tail_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_pop;

    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[head_reg];
    // keep room for a whole header burst
    assign room      = (count_reg <= CntW'(QueueDepth - hhd_pkg::HdrMax));

    always_comb
    begin
        head_next  = head_reg + PtrW'(do_pop);
        tail_next  = tail_reg + PtrW'(push.count);
        count_next = count_reg + CntW'(push.count) - CntW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < hhd_pkg::HdrMax; i++)
        begin
            if (3'(i) < push.count)
            begin
                mem_reg[PtrW'(tail_reg + PtrW'(i))] <= push.data[i];
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(QueueDepth))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(count_reg) + 32'(push.count)) <= 32'(QueueDepth))
        else $error("queue overflow");

endmodule

// ----- rtl/hhd_back.sv -----
// Back end: drains the queue, marks chunk ends and holds the output register.
module hhd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  hhd_pkg::entry_t head,
    input  logic            not_empty,
    output logic            pop,
    input  logic [10:0]     cmd_chunk,
    input  logic [10:0]     acl_chunk,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [7:0]      out_byte,
    output logic            endpoint,
    output logic            chunk_last,
    output logic            packet_last
);

    localparam logic [10:0] ChunkMaxW = 11'(hhd_pkg::ChunkMax);

    logic        out_valid_reg, out_valid_next;
    logic [10:0] chunk_count_reg, chunk_count_next;
    logic [7:0]  out_byte_reg;
    logic        endpoint_reg;
    logic        chunk_last_reg;
    logic        packet_last_reg;

    logic        load;
    logic [10:0] size_raw;
    logic [10:0] size_eff;
    logic [10:0] cnt;
    logic        c_last;

    assign load     = not_empty && (!out_valid_reg || !out_stall);
    assign pop      = load;
    assign size_raw = head.ep ? acl_chunk : cmd_chunk;
    // clamp chunk size to 1..1024
    assign size_eff = (size_raw == 11'd0) ? 11'd1 :
                      (size_raw > ChunkMaxW) ? ChunkMaxW : size_raw;
    assign cnt      = chunk_count_reg + 11'd1;
    assign c_last   = head.pkt_last || (cnt >= size_eff);

    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        chunk_count_next = chunk_count_reg;
        if (load)
        begin
            out_valid_next   = 1'b1;
            chunk_count_next = c_last ? 11'd0 : cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            chunk_count_reg <= 11'd0;
        end
        else
        begin
            out_valid_reg   <= out_valid_next;
            chunk_count_reg <= chunk_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg    <= head.data;
            endpoint_reg    <= head.ep;
            chunk_last_reg  <= c_last;
            packet_last_reg <= head.pkt_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign endpoint    = endpoint_reg;
    assign chunk_last  = chunk_last_reg;
    assign packet_last = packet_last_reg;

    a_pkt_closes_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && packet_last_reg) |-> chunk_last_reg)
        else $error("packet end without chunk end");

    a_chunk_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_count_reg < ChunkMaxW)
        else $error("chunk count reached chunk limit");

endmodule

// ----- rtl/hci_h4_packet_deframer.sv -----
// HCI H4 packet deframer: top level with configuration registers.
//
// Takes one H4 byte per cycle on in_byte while in_stall is low and forwards command and ACL
// packets, type byte removed, to endpoint 0 or 1, marking chunk and packet ends; SCO and
// event packets, unknown type bytes and oversized headers produce nothing. The sustained
// rate is one byte per cycle while out_stall is low. The byte that completes a forwarded
// header pushes the whole header (up to four bytes) into an eight-entry queue at once; the
// output register drains that queue one byte per cycle unless out_stall holds it, so
// in_stall rises whenever fewer than four queue slots are free, which happens only while
// out_stall holds results back. A pushed byte is held in the queue, then the output register.
// Configuration is written through cfg_write/cfg_index/cfg_data: index 0 enable, 1 command
// chunk size, 2 ACL chunk size; the block should be idle during writes.
module hci_h4_packet_deframer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        endpoint,
    output logic        chunk_last,
    output logic        packet_last
);

    logic        enable_reg;
    logic [10:0] cmd_chunk_reg;
    logic [10:0] acl_chunk_reg;

    hhd_pkg::push_t  push;
    hhd_pkg::entry_t head;
    logic            room;
    logic            pop;
    logic            not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            cmd_chunk_reg <= 11'(hhd_pkg::ChunkReset);
            acl_chunk_reg <= 11'(hhd_pkg::ChunkReset);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hhd_pkg::CFG_ENABLE:    enable_reg    <= cfg_data[0];
                hhd_pkg::CFG_CMD_CHUNK: cmd_chunk_reg <= cfg_data;
                hhd_pkg::CFG_ACL_CHUNK: acl_chunk_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    hhd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_stall (in_stall),
        .enable   (enable_reg),
        .room     (room),
        .push     (push)
    );

    hhd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    hhd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .not_empty   (not_empty),
        .pop         (pop),
        .cmd_chunk   (cmd_chunk_reg),
        .acl_chunk   (acl_chunk_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .endpoint    (endpoint),
        .chunk_last  (chunk_last),
        .packet_last (packet_last)
    );

endmodule
